FILE: hdl/pfsn_pkg.sv
// Shared types and constants for the per-field score normalizer.
// Used by the channel interfaces and the core; no dependencies.
package pfsn_pkg;

    localparam int NUM_FIELDS_DEF = 8;
    localparam int COUNT_BITS_DEF = 24;

    localparam int CMD_W = 2;
    localparam int FI_W  = 3;
    localparam int VAL_W = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_IN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_OUT = 2'd2;

    localparam logic [1:0] METHOD_FIFTY = 2'd1;

    // shared divide / square root unit
    localparam int NUM_W = 64;
    localparam int DEN_W = 33;
    localparam int REM_W = 35;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ACCUM = 2'd1,
        CMD_FINAL = 2'd2,
        CMD_NORM  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MEAN_DIV,
        ST_SQUARE,
        ST_TERM_DIV,
        ST_CENTER_DIV,
        ST_VAR_DIV,
        ST_ROOT,
        ST_NORM_DIV,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/pfsn_in_if.sv
// Input channel of the per-field score normalizer: valid/ready plus item payload.
// Depends on pfsn_pkg for field widths.
interface pfsn_in_if;
    logic                           valid;
    logic                           ready;
    logic [pfsn_pkg::CMD_W-1:0]     command;
    logic [pfsn_pkg::FI_W-1:0]      field_index;
    logic                           value_is_null;
    logic signed [pfsn_pkg::VAL_W-1:0] value;
    logic                           last_field;

    modport source (output valid, command, field_index, value_is_null, value, last_field,
                    input ready);
    modport sink (input valid, command, field_index, value_is_null, value, last_field,
                  output ready);
endinterface

FILE: hdl/pfsn_out_if.sv
// Result channel of the per-field score normalizer: valid/ready plus result payload.
// Depends on pfsn_pkg for field widths.
interface pfsn_out_if;
    logic                              valid;
    logic                              ready;
    logic [pfsn_pkg::FI_W-1:0]         out_field_index;
    logic                              result_is_null;
    logic signed [pfsn_pkg::VAL_W-1:0] normalized;
    logic                              end_of_record;
    logic                              null_in_seen;
    logic                              null_out_seen;

    modport source (output valid, out_field_index, result_is_null, normalized, end_of_record,
                    null_in_seen, null_out_seen, input ready);
    modport sink (input valid, out_field_index, result_is_null, normalized, end_of_record,
                  null_in_seen, null_out_seen, output ready);
endinterface

FILE: hdl/per_field_score_normalizer_core.sv
// Per-field Q16.16 score normalizer core: statistics store, sequencer and shared div/sqrt unit.
// Depends on pfsn_pkg, pfsn_in_if and pfsn_out_if.
//
// The block takes one beat at a time and is not ready until that beat is done. Clear, a null
// or ignored accumulate, a min-max finalize and a failed finalize finish in the dispatch
// state. An accumulate runs two passes of the shared restoring divider (mean step and
// deviation term) plus a 48x16 partial-product square. A z-score finalize runs two divides
// and a square root, and skips the root when the variance saturates; a normalize runs one
// divide, and a null normalize none. The shared divide/root unit yields one bit or one root
// digit a cycle. A finished result sits in an output
// register while the next beat is taken in.
module per_field_score_normalizer_core #(
    parameter int NUM_FIELDS = pfsn_pkg::NUM_FIELDS_DEF,
    parameter int COUNT_BITS = pfsn_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfsn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfsn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pfsn_in_if.sink                            i_in,
    pfsn_out_if.source                         o_out
);

    localparam int IW    = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int SUM_W = 32 + COUNT_BITS;
    localparam int DW    = pfsn_pkg::DEN_W;
    localparam int NW    = pfsn_pkg::NUM_W;
    localparam int RW    = pfsn_pkg::REM_W;

    pfsn_pkg::t_state r_state, n_state;

    // configuration and sticky flags
    logic [1:0] r_method;
    logic       r_flag_in, r_flag_out, r_sticky_in, r_sticky_out;

    // per-field statistics
    logic [COUNT_BITS-1:0] r_count  [NUM_FIELDS];
    logic [SUM_W-1:0]      r_sum    [NUM_FIELDS];
    logic [47:0]           r_mean   [NUM_FIELDS];
    logic [63:0]           r_m2     [NUM_FIELDS];
    logic signed [31:0]    r_min    [NUM_FIELDS];
    logic signed [31:0]    r_max    [NUM_FIELDS];
    logic [31:0]           r_center [NUM_FIELDS];
    logic [31:0]           r_scale  [NUM_FIELDS];
    logic                  r_inv    [NUM_FIELDS];

    // latched beat
    pfsn_pkg::t_cmd              r_cmd;
    logic [pfsn_pkg::FI_W-1:0]   r_fi;
    logic                        r_null, r_last;
    logic signed [31:0]          r_x;

    // shared divide / root unit
    logic [NW-1:0]              r_num, r_quo;
    logic [RW-1:0]              r_rem;
    logic [DW-1:0]              r_den;
    logic                       r_sqrt;
    logic [pfsn_pkg::CNT_W-1:0] r_cnt;
    logic                       ld, ld_sqrt;
    logic [NW-1:0]              ld_num;
    logic [DW-1:0]              ld_den;
    logic [pfsn_pkg::CNT_W-1:0] ld_steps;
    logic [RW-1:0]              w_rem_sh, w_opb;
    logic [RW:0]                w_sub;
    logic                       w_take;

    // work registers
    logic        r_dneg, r_sneg, r_nneg, r_fifty, r_rnull;
    logic [47:0] r_dmag, r_mq;
    logic [95:0] r_acc;
    logic [1:0]  r_k;
    logic [31:0] r_ctr, r_res;

    // output register
    logic                      r_ov, r_o_null, r_o_last, r_o_nin, r_o_nout;
    logic [pfsn_pkg::FI_W-1:0] r_o_fi;
    logic [31:0]               r_o_val;

    // current field view
    logic [IW-1:0]         w_idx;
    logic                  w_okf, w_full;
    logic [COUNT_BITS-1:0] c_n;
    logic [SUM_W-1:0]      c_sum, w_smag;
    logic [47:0]           c_mean, w_dmag, w_s, w_term;
    logic [63:0]           c_m2;
    logic signed [31:0]    c_min, c_max;
    logic [31:0]           c_center, c_scale;
    logic                  c_inv;
    logic [DW-1:0]         w_np1;
    logic signed [48:0]    w_d;
    logic                  w_sneg, w_rnull, w_nneg, w_fifty, w_advance;
    logic signed [32:0]    w_diff;
    logic [32:0]           w_nmag;
    logic [36:0]           w_nk;
    logic [NW-1:0]         w_nnum;
    logic [15:0]           w_slice;
    logic [63:0]           w_pp;
    logic [95:0]           w_ppsh;
    logic signed [63:0]    w_rs;
    logic [31:0]           w_sat, w_q32;
    logic [65:0]           w_m2sum;

    assign w_idx    = IW'(r_fi);
    assign w_okf    = (7'(r_fi) < 7'(NUM_FIELDS));
    assign c_n      = r_count[w_idx];
    assign c_sum    = r_sum[w_idx];
    assign c_mean   = r_mean[w_idx];
    assign c_m2     = r_m2[w_idx];
    assign c_min    = r_min[w_idx];
    assign c_max    = r_max[w_idx];
    assign c_center = r_center[w_idx];
    assign c_scale  = r_scale[w_idx];
    assign c_inv    = r_inv[w_idx];
    assign w_full   = &c_n;
    assign w_np1    = DW'(c_n) + DW'(1);

    assign w_d    = {r_x[31], r_x, 16'b0} - {c_mean[47], c_mean};
    assign w_dmag = w_d[48] ? 48'(-w_d) : w_d[47:0];

    assign w_sneg = c_sum[SUM_W-1];
    assign w_smag = w_sneg ? (~c_sum + SUM_W'(1)) : c_sum;

    assign w_rnull = r_null || !w_okf || c_inv || (c_scale == 32'd0);
    assign w_diff  = {r_x[31], r_x} - {c_center[31], c_center};
    assign w_nneg  = w_diff[32];
    assign w_nmag  = w_nneg ? 33'(-w_diff) : w_diff;
    assign w_fifty = (r_method == pfsn_pkg::METHOD_FIFTY);
    assign w_nk    = w_fifty ? (37'({w_nmag, 3'b0}) + 37'({w_nmag, 1'b0})) : 37'(w_nmag);
    assign w_nnum  = {11'b0, w_nk, 16'b0} + 64'(c_scale[31:1]);

    assign w_s     = r_acc[95:48];
    assign w_term  = w_s - r_quo[47:0];
    assign w_m2sum = 66'(c_m2) + 66'(w_term);

    always_comb begin
        w_slice = r_dmag[15:0];
        w_ppsh  = '0;
        case (r_k)
            2'd1:    w_slice = r_dmag[31:16];
            2'd2:    w_slice = r_dmag[47:32];
            default: w_slice = r_dmag[15:0];
        endcase
        w_pp = r_dmag * w_slice;
        case (r_k)
            2'd1:    w_ppsh = {16'b0, w_pp, 16'b0};
            2'd2:    w_ppsh = {w_pp, 32'b0};
            default: w_ppsh = 96'(w_pp);
        endcase
    end

    assign w_rs  = (r_nneg ? -$signed(r_quo) : $signed(r_quo))
                 + (r_fifty ? 64'sd3276800 : 64'sd0);
    assign w_sat = (w_rs > 64'sd2147483647)  ? 32'h7FFF_FFFF :
                   (w_rs < -64'sd2147483648) ? 32'h8000_0000 : w_rs[31:0];
    assign w_q32 = r_quo[31:0];

    // shared unit step
    always_comb begin
        w_rem_sh = r_sqrt ? {r_rem[32:0], r_num[NW-1:NW-2]} : {r_rem[33:0], r_num[NW-1]};
        w_opb    = r_sqrt ? {r_quo[32:0], 2'b01} : {2'b00, r_den};
        w_sub    = {1'b0, w_rem_sh} - {1'b0, w_opb};
        w_take   = !w_sub[RW];
    end

    assign w_advance = (r_state == pfsn_pkg::ST_OUT) && (!r_ov || o_out.ready);

    // next state and unit loads
    always_comb begin
        n_state  = r_state;
        ld       = 1'b0;
        ld_sqrt  = 1'b0;
        ld_num   = '0;
        ld_den   = '0;
        ld_steps = pfsn_pkg::DIV_STEPS;
        unique case (r_state)
            pfsn_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = pfsn_pkg::ST_DISPATCH;
            end
            pfsn_pkg::ST_DISPATCH: begin
                n_state = pfsn_pkg::ST_IDLE;
                unique case (r_cmd)
                    pfsn_pkg::CMD_ACCUM: begin
                        if (!r_null && w_okf && !w_full) begin
                            ld      = 1'b1;
                            ld_num  = 64'(w_dmag);
                            ld_den  = w_np1;
                            n_state = pfsn_pkg::ST_MEAN_DIV;
                        end
                    end
                    pfsn_pkg::CMD_FINAL: begin
                        if (w_okf && !r_method[1] && (c_n >= COUNT_BITS'(2))) begin
                            ld      = 1'b1;
                            ld_num  = 64'(w_smag) + 64'(c_n >> 1);
                            ld_den  = DW'(c_n);
                            n_state = pfsn_pkg::ST_CENTER_DIV;
                        end
                    end
                    pfsn_pkg::CMD_NORM: begin
                        if (w_rnull) begin
                            n_state = pfsn_pkg::ST_OUT;
                        end else begin
                            ld      = 1'b1;
                            ld_num  = w_nnum;
                            ld_den  = DW'(c_scale);
                            n_state = pfsn_pkg::ST_NORM_DIV;
                        end
                    end
                    default: n_state = pfsn_pkg::ST_IDLE;
                endcase
            end
            pfsn_pkg::ST_MEAN_DIV: begin
                if (r_cnt == '0) n_state = pfsn_pkg::ST_SQUARE;
            end
            pfsn_pkg::ST_SQUARE: begin
                if (r_k == 2'd3) begin
                    ld      = 1'b1;
                    ld_num  = 64'(w_s);
                    ld_den  = w_np1;
                    n_state = pfsn_pkg::ST_TERM_DIV;
                end
            end
            pfsn_pkg::ST_TERM_DIV: begin
                if (r_cnt == '0) n_state = pfsn_pkg::ST_IDLE;
            end
            pfsn_pkg::ST_CENTER_DIV: begin
                if (r_cnt == '0) begin
                    ld      = 1'b1;
                    ld_num  = c_m2;
                    ld_den  = DW'(c_n) - DW'(1);
                    n_state = pfsn_pkg::ST_VAR_DIV;
                end
            end
            pfsn_pkg::ST_VAR_DIV: begin
                if (r_cnt == '0) begin
                    if (r_quo[63:48] != 16'd0) begin
                        n_state = pfsn_pkg::ST_IDLE;
                    end else begin
                        ld       = 1'b1;
                        ld_sqrt  = 1'b1;
                        ld_num   = {r_quo[47:0], 16'b0};
                        ld_steps = pfsn_pkg::SQRT_STEPS;
                        n_state  = pfsn_pkg::ST_ROOT;
                    end
                end
            end
            pfsn_pkg::ST_ROOT: begin
                if (r_cnt == '0) n_state = pfsn_pkg::ST_IDLE;
            end
            pfsn_pkg::ST_NORM_DIV: begin
                if (r_cnt == '0) n_state = pfsn_pkg::ST_OUT;
            end
            pfsn_pkg::ST_OUT: begin
                if (w_advance) n_state = pfsn_pkg::ST_IDLE;
            end
            default: n_state = pfsn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pfsn_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // control state and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_ov         <= 1'b0;
            r_method     <= 2'd0;
            r_flag_in    <= 1'b0;
            r_flag_out   <= 1'b0;
            r_sticky_in  <= 1'b0;
            r_sticky_out <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_count[i]  <= '0;
                r_sum[i]    <= '0;
                r_mean[i]   <= '0;
                r_m2[i]     <= '0;
                r_min[i]    <= 32'sh7FFF_FFFF;
                r_max[i]    <= 32'sh8000_0000;
                r_center[i] <= '0;
                r_scale[i]  <= '0;
                r_inv[i]    <= 1'b1;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfsn_pkg::CFG_METHOD:   r_method   <= i_cfg_data;
                    pfsn_pkg::CFG_NULL_IN:  r_flag_in  <= i_cfg_data[0];
                    pfsn_pkg::CFG_NULL_OUT: r_flag_out <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (ld)                r_cnt <= ld_steps;
            else if (r_cnt != '0)  r_cnt <= r_cnt - 1'b1;

            if (w_advance) begin
                r_ov <= 1'b1;
                if (r_rnull && r_flag_out) r_sticky_out <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                pfsn_pkg::ST_DISPATCH: begin
                    if (r_cmd == pfsn_pkg::CMD_CLEAR) begin
                        for (int i = 0; i < NUM_FIELDS; i++) begin
                            r_count[i]  <= '0;
                            r_sum[i]    <= '0;
                            r_mean[i]   <= '0;
                            r_m2[i]     <= '0;
                            r_min[i]    <= 32'sh7FFF_FFFF;
                            r_max[i]    <= 32'sh8000_0000;
                            r_center[i] <= '0;
                            r_scale[i]  <= '0;
                            r_inv[i]    <= 1'b1;
                        end
                    end
                    if (r_cmd == pfsn_pkg::CMD_ACCUM && r_null && r_flag_in)
                        r_sticky_in <= 1'b1;
                    if (r_cmd == pfsn_pkg::CMD_FINAL && w_okf) begin
                        if (r_method[1] && c_n != '0) begin
                            r_center[w_idx] <= c_min;
                            r_scale[w_idx]  <= c_max - c_min;
                            r_inv[w_idx]    <= (c_max == c_min);
                        end else begin
                            r_center[w_idx] <= '0;
                            r_scale[w_idx]  <= '0;
                            r_inv[w_idx]    <= 1'b1;
                        end
                    end
                end
                pfsn_pkg::ST_TERM_DIV: begin
                    if (r_cnt == '0) begin
                        r_count[w_idx] <= c_n + 1'b1;
                        r_sum[w_idx]   <= c_sum + SUM_W'(r_x);
                        r_mean[w_idx]  <= r_dneg ? (c_mean - r_mq) : (c_mean + r_mq);
                        r_m2[w_idx]    <= (w_m2sum[65:64] != 2'd0) ? '1 : w_m2sum[63:0];
                        if (r_x < c_min) r_min[w_idx] <= r_x;
                        if (r_x > c_max) r_max[w_idx] <= r_x;
                    end
                end
                pfsn_pkg::ST_VAR_DIV: begin
                    if (r_cnt == '0 && r_quo[63:48] != 16'd0) begin
                        r_center[w_idx] <= r_ctr;
                        r_scale[w_idx]  <= '1;
                        r_inv[w_idx]    <= 1'b0;
                    end
                end
                pfsn_pkg::ST_ROOT: begin
                    if (r_cnt == '0) begin
                        r_center[w_idx] <= r_ctr;
                        r_scale[w_idx]  <= w_q32;
                        r_inv[w_idx]    <= (w_q32 == 32'd0);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == pfsn_pkg::ST_IDLE && i_in.valid) begin
            r_cmd  <= pfsn_pkg::t_cmd'(i_in.command);
            r_fi   <= i_in.field_index;
            r_null <= i_in.value_is_null;
            r_x    <= i_in.value;
            r_last <= i_in.last_field;
        end

        if (ld) begin
            r_num  <= ld_num;
            r_den  <= ld_den;
            r_sqrt <= ld_sqrt;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_cnt != '0) begin
            r_num <= r_sqrt ? {r_num[NW-3:0], 2'b00} : {r_num[NW-2:0], 1'b0};
            r_rem <= w_take ? w_sub[RW-1:0] : w_rem_sh;
            r_quo <= {r_quo[NW-2:0], w_take};
        end

        case (r_state)
            pfsn_pkg::ST_DISPATCH: begin
                r_dneg  <= w_d[48];
                r_dmag  <= w_dmag;
                r_sneg  <= w_sneg;
                r_nneg  <= w_nneg;
                r_fifty <= w_fifty;
                r_rnull <= 1'b1;
                r_res   <= '0;
            end
            pfsn_pkg::ST_MEAN_DIV: begin
                r_mq  <= r_quo[47:0];
                r_acc <= '0;
                r_k   <= 2'd0;
            end
            pfsn_pkg::ST_SQUARE: begin
                if (r_k != 2'd3) begin
                    r_acc <= r_acc + w_ppsh;
                    r_k   <= r_k + 1'b1;
                end
            end
            pfsn_pkg::ST_CENTER_DIV: begin
                r_ctr <= r_sneg ? (~w_q32 + 32'd1) : w_q32;
            end
            pfsn_pkg::ST_NORM_DIV: begin
                r_rnull <= 1'b0;
                r_res   <= w_sat;
            end
            default: ;
        endcase

        if (w_advance) begin
            r_o_fi   <= r_fi;
            r_o_null <= r_rnull;
            r_o_val  <= r_res;
            r_o_last <= r_last;
            r_o_nin  <= r_sticky_in;
            r_o_nout <= r_sticky_out | (r_rnull & r_flag_out);
        end
    end

    assign i_in.ready            = (r_state == pfsn_pkg::ST_IDLE);
    assign o_out.valid           = r_ov;
    assign o_out.out_field_index = r_o_fi;
    assign o_out.result_is_null  = r_o_null;
    assign o_out.normalized      = r_o_val;
    assign o_out.end_of_record   = r_o_last;
    assign o_out.null_in_seen    = r_o_nin;
    assign o_out.null_out_seen   = r_o_nout;

endmodule
